// File: rtl/pvke_pkg.sv
// Shared types, scan codes and segment tables for the keypad value entry block.
`timescale 1ns / 1ps

package pvke_pkg;

  localparam int NUM_DEVICES_DEF = 9;
  localparam int DEV_W           = 4;   // device index and device count
  localparam int VAL_W           = 7;   // stored value, 0..99
  localparam int DIG_W           = 4;
  localparam int SEG_W           = 7;
  localparam int SW_W            = 9;
  localparam int IN_DATA_W       = 24;
  localparam int OUT_DATA_W      = 32;

  typedef enum logic [1:0] {
    KIND_SCAN   = 2'd0,
    KIND_GROUP  = 2'd1,
    KIND_SWITCH = 2'd2
  } kind_t;

  localparam logic [1:0] GROUP_UNUSED = 2'd3;

  localparam logic [7:0] SC_BREAK = 8'hF0;
  localparam logic [7:0] SC_KEY_A = 8'h1C;
  localparam logic [7:0] SC_KEY_B = 8'h32;
  localparam logic [7:0] SC_KEY_C = 8'h21;
  localparam logic [7:0] SC_ENTER = 8'h5A;

  localparam logic [SW_W-1:0] SW_MASK = 9'h1FF;

  typedef struct packed {
    logic [1:0]      kind;
    logic [7:0]      scan_byte;
    logic [1:0]      group_select;
    logic [SW_W-1:0] switches;
  } item_t;

  typedef struct packed {
    logic             display_update;
    logic [SEG_W-1:0] letter_segments;
    logic [SEG_W-1:0] tens_segments;
    logic [SEG_W-1:0] ones_segments;
    logic [SW_W-1:0]  device_leds;
  } res_t;

  typedef struct packed {
    logic             hit;
    logic [DIG_W-1:0] digit;
  } digit_key_t;

  function automatic digit_key_t digit_of(input logic [7:0] b);
    digit_key_t r;
    r.hit = 1'b1;
    unique case (b)
      8'h45:   r.digit = 4'd0;
      8'h16:   r.digit = 4'd1;
      8'h1E:   r.digit = 4'd2;
      8'h26:   r.digit = 4'd3;
      8'h25:   r.digit = 4'd4;
      8'h2E:   r.digit = 4'd5;
      8'h36:   r.digit = 4'd6;
      8'h3D:   r.digit = 4'd7;
      8'h3E:   r.digit = 4'd8;
      8'h46:   r.digit = 4'd9;
      default: begin
        r.hit   = 1'b0;
        r.digit = 4'd0;
      end
    endcase
    return r;
  endfunction

  function automatic logic [SEG_W-1:0] seg_of(input logic [DIG_W-1:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h67;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  function automatic logic [SEG_W-1:0] seg_letter(input logic [1:0] k);
    logic [SEG_W-1:0] s;
    unique case (k)
      2'd0:    s = 7'h77;
      2'd1:    s = 7'h7C;
      2'd2:    s = 7'h39;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  // v / 10 by reciprocal, exact over the 7-bit range
  function automatic logic [DIG_W-1:0] div10(input logic [VAL_W-1:0] v);
    logic [14:0] p;
    p = 15'(v) * 15'd205;
    return p[14:11];
  endfunction

endpackage

// File: rtl/pvke_in_stage.sv
// Input register stage: holds one accepted item until the core takes it.
`timescale 1ns / 1ps

module pvke_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  pvke_pkg::item_t in_item,
  input  logic          advance,
  output logic          item_valid,
  output pvke_pkg::item_t item
);
  import pvke_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_tready = !valid_r || advance;
  assign valid_nxt = (in_tvalid && in_tready) || (valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// File: rtl/pvke_entry_core.sv
// Entry state and single-pass item decode: device selection, digit buffer, commit.
`timescale 1ns / 1ps

module pvke_entry_core #(
  parameter int NUM_DEVICES = pvke_pkg::NUM_DEVICES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  pvke_pkg::item_t item,
  output pvke_pkg::res_t  res
);
  import pvke_pkg::*;

  localparam int IDX_W = $clog2(NUM_DEVICES);
  localparam logic [DEV_W-1:0] NUM_DEV = DEV_W'(NUM_DEVICES);

  logic [VAL_W-1:0] stored_r  [NUM_DEVICES];
  logic [VAL_W-1:0] stored_nxt[NUM_DEVICES];
  logic [DEV_W-1:0] chosen_r, chosen_nxt;
  logic [1:0]       chosen_key_r, chosen_key_nxt;   // chosen device mod 3
  logic [1:0]       group_r, group_nxt;
  logic             entering_r, entering_nxt;
  logic [1:0]       held_r, held_nxt;
  logic [DIG_W-1:0] dig0_r, dig0_nxt, dig1_r, dig1_nxt;
  logic             skip_r, skip_nxt;
  logic [DEV_W-1:0] count_r, count_nxt;
  logic [SW_W-1:0]  sw_r, sw_nxt;

  always_comb begin
    digit_key_t       dk;
    logic [1:0]       k;
    logic [DEV_W-1:0] dev;
    logic [VAL_W-1:0] v;
    logic [DIG_W-1:0] tens;
    logic [DIG_W-1:0] dig0_eff;
    logic [1:0]       held_eff;
    logic [15:0]      mask;

    stored_nxt     = stored_r;
    chosen_nxt     = chosen_r;
    chosen_key_nxt = chosen_key_r;
    group_nxt      = group_r;
    entering_nxt   = entering_r;
    held_nxt       = held_r;
    dig0_nxt       = dig0_r;
    dig1_nxt       = dig1_r;
    skip_nxt       = skip_r;
    count_nxt      = count_r;
    sw_nxt         = sw_r;
    res            = '0;

    dk       = digit_of(item.scan_byte);
    k        = (item.scan_byte == SC_KEY_A) ? 2'd0 :
               (item.scan_byte == SC_KEY_B) ? 2'd1 : 2'd2;
    dev      = DEV_W'(group_r) * DEV_W'(3) + DEV_W'(k);
    v        = stored_r[dev[IDX_W-1:0]];
    tens     = div10(v);
    dig0_eff = entering_r ? dig0_r : '0;
    held_eff = entering_r ? held_r : 2'd0;

    case (item.kind)
      KIND_SCAN: begin
        if (skip_r) begin
          skip_nxt = 1'b0;
        end else if (item.scan_byte == SC_BREAK) begin
          skip_nxt = 1'b1;
        end else if (item.scan_byte == SC_KEY_A || item.scan_byte == SC_KEY_B ||
                     item.scan_byte == SC_KEY_C) begin
          if (dev < NUM_DEV) begin
            chosen_nxt          = dev;
            chosen_key_nxt      = k;
            entering_nxt        = 1'b0;
            held_nxt            = 2'd0;
            res.display_update  = 1'b1;
            res.letter_segments = seg_letter(k);
            res.tens_segments   = seg_of(tens);
            res.ones_segments   = seg_of(DIG_W'(v - VAL_W'(tens) * VAL_W'(10)));
          end
        end else if (item.scan_byte == SC_ENTER) begin
          if (entering_r && held_r != 2'd0 && chosen_r < NUM_DEV) begin
            res.display_update  = 1'b1;
            res.letter_segments = seg_letter(chosen_key_r);
            if (held_r == 2'd2) begin
              stored_nxt[chosen_r[IDX_W-1:0]] =
                VAL_W'(dig0_r) * VAL_W'(10) + VAL_W'(dig1_r);
              res.tens_segments = seg_of(dig0_r);
              res.ones_segments = seg_of(dig1_r);
            end else begin
              stored_nxt[chosen_r[IDX_W-1:0]] = VAL_W'(dig0_r);
              res.tens_segments = seg_of('0);
              res.ones_segments = seg_of(dig0_r);
            end
            entering_nxt = 1'b0;
            if (count_r < NUM_DEV) begin
              count_nxt = count_r + DEV_W'(1);
            end
          end
          held_nxt = 2'd0;
          dig0_nxt = '0;
          dig1_nxt = '0;
        end else if (dk.hit) begin
          entering_nxt = 1'b1;
          if (!entering_r) begin
            held_nxt = 2'd0;
            dig0_nxt = '0;
            dig1_nxt = '0;
          end
          if (held_eff < 2'd2) begin
            if (held_eff == 2'd0) begin
              dig0_nxt = dk.digit;
            end else begin
              dig1_nxt = dk.digit;
            end
            held_nxt            = held_eff + 2'd1;
            res.display_update  = 1'b1;
            res.letter_segments = seg_letter(chosen_key_r);
            res.tens_segments   = seg_of((held_eff == 2'd1) ? dig0_eff : '0);
            res.ones_segments   = seg_of(dk.digit);
          end
        end
      end
      KIND_GROUP: begin
        if (item.group_select != GROUP_UNUSED) begin
          group_nxt = item.group_select;
        end
      end
      KIND_SWITCH: begin
        sw_nxt = item.switches & SW_MASK;
      end
      default: ;
    endcase

    // LEDs follow the count after this item's commit
    mask            = (16'd1 << count_nxt) - 16'd1;
    res.device_leds = sw_nxt & mask[SW_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_DEVICES; i++) begin
        stored_r[i] <= '0;
      end
      chosen_r     <= '0;
      chosen_key_r <= '0;
      group_r      <= '0;
      entering_r   <= 1'b0;
      held_r       <= '0;
      dig0_r       <= '0;
      dig1_r       <= '0;
      skip_r       <= 1'b0;
      count_r      <= '0;
      sw_r         <= '0;
    end else if (step) begin
      stored_r     <= stored_nxt;
      chosen_r     <= chosen_nxt;
      chosen_key_r <= chosen_key_nxt;
      group_r      <= group_nxt;
      entering_r   <= entering_nxt;
      held_r       <= held_nxt;
      dig0_r       <= dig0_nxt;
      dig1_r       <= dig1_nxt;
      skip_r       <= skip_nxt;
      count_r      <= count_nxt;
      sw_r         <= sw_nxt;
    end
  end

endmodule

// File: rtl/ps2_keypad_value_entry.sv
// Top level: keypad value entry, input stage, entry core and result register.
//
//   channel   dir  handshake            tdata / tuser
//   in_       in   in_tvalid/in_tready  24-bit data, 2-bit kind
//   out_      out  out_tvalid/out_tready 32-bit data, 1-bit display flag
//
// Every item gives one result, held in the input register and then in the result
// register; one item per cycle is sustained while the output takes results, set
// by the single pass through the entry core between these two registers.
// Synchronous active-low reset clears all entry state and both stages.
// A stalled output holds its result; the input stage keeps taking items
// until it too is full.
`timescale 1ns / 1ps

module ps2_keypad_value_entry #(
  parameter int NUM_DEVICES = pvke_pkg::NUM_DEVICES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [7:0] scan_byte, [9:8] group_select, [18:10] switches, rest zero
  input  logic [pvke_pkg::IN_DATA_W-1:0]    in_tdata,
  // [1:0] kind
  input  logic [1:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [6:0] letter_segments, [13:7] tens_segments, [20:14] ones_segments,
  // [29:21] device_leds, rest zero
  output logic [pvke_pkg::OUT_DATA_W-1:0]   out_tdata,
  // [0] display_update
  output logic                              out_tuser
);
  import pvke_pkg::*;

  item_t in_item, item;
  res_t  res, out_res_r;
  logic  item_valid, advance, load;
  logic  out_valid_r, out_valid_nxt;

  assign in_item.kind         = in_tuser;
  assign in_item.scan_byte    = in_tdata[7:0];
  assign in_item.group_select = in_tdata[9:8];
  assign in_item.switches     = in_tdata[18:10];

  assign load    = !out_valid_r || out_tready;
  assign advance = item_valid && load;

  pvke_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  pvke_entry_core #(
    .NUM_DEVICES (NUM_DEVICES)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (item),
    .res   (res)
  );

  assign out_valid_nxt = load ? item_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.display_update;
  assign out_tdata  = {2'b00, out_res_r.device_leds, out_res_r.ones_segments,
                       out_res_r.tens_segments, out_res_r.letter_segments};

  // a blank display carries no segments
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[20:0] == 21'd0)
    else $error("segments set without display update");

  // a shown display always carries one of the three device letters
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      out_tdata[6:0] == 7'h77 || out_tdata[6:0] == 7'h7C || out_tdata[6:0] == 7'h39)
    else $error("bad device letter");

  // LEDs never light above the device bank
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[29:21] >> NUM_DEVICES) == 9'd0)
    else $error("LED beyond device bank");

  // an item moving out of the input stage shows up as a result next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_tvalid)
    else $error("result lost after input stage advance");

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the keypad value entry block.
`timescale 1ns / 1ps

module testbench;
  import pvke_pkg::*;

  localparam int NUM_DEVS    = NUM_DEVICES_DEF;
  localparam int HOLD_CYCLES = 80;
  localparam int TAIL_CYCLES = 12;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 1150;

  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  localparam logic [7:0] DIGIT_CODES [10] = '{
    8'h45, 8'h16, 8'h1E, 8'h26, 8'h25, 8'h2E, 8'h36, 8'h3D, 8'h3E, 8'h46
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [1:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  ps2_keypad_value_entry i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  class entry_scoreboard;
    typedef struct packed {
      logic             update;
      logic [SEG_W-1:0] letter;
      logic [SEG_W-1:0] tens;
      logic [SEG_W-1:0] ones;
      logic [SW_W-1:0]  leds;
    } display_t;

    display_t expected_displays[$];

    logic [VAL_W-1:0] stored_values [NUM_DEVS];
    logic [DEV_W-1:0] chosen_device;
    logic [1:0]       active_group;
    logic             entering;
    logic [1:0]       digits_held;
    logic [DIG_W-1:0] digit_store [2];
    logic             skip_next_byte;
    logic [DEV_W-1:0] device_count;
    logic [SW_W-1:0]  last_switches;

    int mismatches;
    int results_seen;
    int displays_seen;
    int commits;

    function new();
      foreach (stored_values[i]) stored_values[i] = '0;
      chosen_device  = '0;
      active_group   = '0;
      entering       = 1'b0;
      digits_held    = '0;
      digit_store[0] = '0;
      digit_store[1] = '0;
      skip_next_byte = 1'b0;
      device_count   = '0;
      last_switches  = '0;
    endfunction

    function logic [SEG_W-1:0] digit_segments(int d);
      case (d)
        0:       return 7'h3F;
        1:       return 7'h06;
        2:       return 7'h5B;
        3:       return 7'h4F;
        4:       return 7'h66;
        5:       return 7'h6D;
        6:       return 7'h7D;
        7:       return 7'h07;
        8:       return 7'h7F;
        9:       return 7'h67;
        default: return 7'h00;
      endcase
    endfunction

    function display_t shown(int tens, int ones);
      display_t e;
      e        = '0;
      e.update = 1'b1;
      case (chosen_device % 3)
        0:       e.letter = 7'h77;
        1:       e.letter = 7'h7C;
        default: e.letter = 7'h39;
      endcase
      e.tens = digit_segments(tens);
      e.ones = digit_segments(ones);
      return e;
    endfunction

    // Advance the entry state by one transferred item and queue its display.
    function void note_item(logic [1:0] kind, logic [IN_DATA_W-1:0] data);
      display_t   e;
      logic [7:0] code;
      int         d;
      int         dev;
      int         v;
      e    = '0;
      code = data[7:0];
      d    = -1;
      case (kind)
        KIND_SCAN: begin
          if (skip_next_byte) begin
            skip_next_byte = 1'b0;
          end else if (code == SC_BREAK) begin
            skip_next_byte = 1'b1;
          end else if (code == SC_KEY_A || code == SC_KEY_B || code == SC_KEY_C) begin
            dev = 3 * active_group + ((code == SC_KEY_A) ? 0 : (code == SC_KEY_B) ? 1 : 2);
            if (dev < NUM_DEVS) begin
              chosen_device = DEV_W'(dev);
              entering      = 1'b0;
              digits_held   = '0;
              v             = stored_values[dev];
              e             = shown(v / 10, v % 10);
            end
          end else if (code == SC_ENTER) begin
            if (entering && digits_held > 0 && chosen_device < NUM_DEVS) begin
              v = (digits_held == 2) ? digit_store[0] * 10 + digit_store[1] : digit_store[0];
              stored_values[chosen_device] = VAL_W'(v);
              entering = 1'b0;
              if (device_count < NUM_DEVS) device_count++;
              commits++;
              e = shown(v / 10, v % 10);
            end
            digits_held    = '0;
            digit_store[0] = '0;
            digit_store[1] = '0;
          end else begin
            foreach (DIGIT_CODES[i]) if (DIGIT_CODES[i] == code) d = i;
            if (d >= 0) begin
              if (!entering) begin
                entering       = 1'b1;
                digits_held    = '0;
                digit_store[0] = '0;
                digit_store[1] = '0;
              end
              // a third digit falls through here untouched
              if (digits_held < 2) begin
                digit_store[digits_held] = DIG_W'(d);
                digits_held++;
                e = shown(digits_held > 1 ? int'(digit_store[0]) : 0,
                          digit_store[digits_held - 1]);
              end
            end
          end
        end
        KIND_GROUP: if (data[9:8] != GROUP_UNUSED) active_group = data[9:8];
        KIND_SWITCH: last_switches = data[18:10];
        default: ;
      endcase
      e.leds = last_switches & SW_W'((1 << device_count) - 1);
      expected_displays.push_back(e);
    endfunction

    function void check_result(logic update, logic [OUT_DATA_W-1:0] data);
      display_t e;
      display_t got;
      got = {update, data[6:0], data[13:7], data[20:14], data[29:21]};
      results_seen++;
      if (expected_displays.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: flag=%0d letter=%02h tens=%02h ones=%02h leds=%03h",
                   got.update, got.letter, got.tens, got.ones, got.leds);
        return;
      end
      e = expected_displays.pop_front();
      if (e.update) displays_seen++;
      if (got != e) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch on result %0d:", results_seen);
          $display("  expected flag=%0d letter=%02h tens=%02h ones=%02h leds=%03h",
                   e.update, e.letter, e.tens, e.ones, e.leds);
          $display("  actual   flag=%0d letter=%02h tens=%02h ones=%02h leds=%03h",
                   got.update, got.letter, got.tens, got.ones, got.leds);
        end
      end
    endfunction
  endclass

  entry_scoreboard tracker;

  int cycles;
  int items_sent;
  int burst_left;
  int held_back_cycles;
  bit no_gaps;
  bit hold_request;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && !in_tready) held_back_cycles++;
    if (rst_n && out_tvalid && out_tready) tracker.check_result(out_tuser, out_tdata);
  end

  // Receiver: changes its stall pattern every so often; a hold request blocks it outright.
  initial begin
    int mode;
    int mode_left;
    int phase;
    mode      = 0;
    mode_left = 0;
    phase     = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        phase++;
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          2:       out_tready <= ($urandom_range(0, 3) != 0);
          default: out_tready <= (phase % 5) >= 2;
        endcase
      end
    end
  end

  task automatic send(input logic [1:0] kind, input logic [7:0] code,
                      input logic [1:0] grp, input logic [SW_W-1:0] sw);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {5'b0, sw, grp, code};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_item(kind, {5'b0, sw, grp, code});
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0 && !no_gaps) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 12);
    end
  endtask

  // unused fields of every item sent by these tasks carry random bits, the block must ignore them
  task automatic press(input logic [7:0] code);
    send(KIND_SCAN, code, 2'($urandom), SW_W'($urandom));
  endtask

  task automatic choose_group(input logic [1:0] grp);
    send(KIND_GROUP, 8'($urandom), grp, SW_W'($urandom));
  endtask

  task automatic sample_switches(input logic [SW_W-1:0] sw);
    send(KIND_SWITCH, 8'($urandom), 2'($urandom), sw);
  endtask

  // make code, sometimes followed by its break sequence as a real keyboard sends
  task automatic tap(input logic [7:0] code);
    press(code);
    if ($urandom_range(0, 2) == 0) begin
      press(SC_BREAK);
      press(code);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (tracker.expected_displays.size() != 0) @(posedge clk);
  endtask

  initial begin
    int  pick;
    int  n_digits;
    bit  hold_done;
    bit  pause_done;
    tracker    = new();
    hold_done  = 1'b0;
    pause_done = 1'b0;
    burst_left = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. With nine devices and three groups every selection lands
    // inside the bank, so the out-of-bank selection cannot be provoked.
    sample_switches(9'h1FF);
    press(SC_KEY_A);
    press(DIGIT_CODES[9]);
    press(DIGIT_CODES[9]);
    press(DIGIT_CODES[5]);           // third digit, ignored
    press(SC_ENTER);                 // commits 99
    press(SC_ENTER);                 // enter with nothing held
    choose_group(2'd2);
    press(SC_KEY_C);
    press(DIGIT_CODES[0]);
    press(SC_ENTER);                 // single-digit zero
    choose_group(GROUP_UNUSED);      // ignored, group stays 2
    press(SC_KEY_B);
    press(SC_BREAK);
    press(SC_BREAK);                 // skipped although it is a break prefix
    press(SC_KEY_A);
    press(SC_BREAK);
    press(SC_KEY_A);                 // skipped
    press(8'h00);
    press(8'hFF);
    send(KIND_UNKNOWN, 8'hFF, 2'd3, 9'h1FF);
    sample_switches(9'h000);
    choose_group(2'd0);
    press(SC_KEY_A);
    press(DIGIT_CODES[1]);
    press(SC_ENTER);
    drain();

    while (items_sent < ITEM_TARGET) begin
      if (!hold_done && items_sent > 400) begin
        // receiver blocks while the sender keeps offering, so the block backs up
        hold_request = 1'b1;
        no_gaps      = 1'b1;
        repeat (24) press(DIGIT_CODES[$urandom_range(0, 9)]);
        no_gaps   = 1'b0;
        hold_done = 1'b1;
      end
      if (!pause_done && items_sent > 800) begin
        drain();
        pause_done = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        if ($urandom_range(0, 2) == 0)
          choose_group(($urandom_range(0, 9) == 0) ? GROUP_UNUSED : 2'($urandom_range(0, 2)));
        case ($urandom_range(0, 2))
          0:       tap(SC_KEY_A);
          1:       tap(SC_KEY_B);
          default: tap(SC_KEY_C);
        endcase
        n_digits = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(1, 2);
        repeat (n_digits) tap(DIGIT_CODES[$urandom_range(0, 9)]);
        if ($urandom_range(0, 9) != 0) tap(SC_ENTER);
      end else if (pick < 65) begin
        repeat ($urandom_range(1, 3)) tap(DIGIT_CODES[$urandom_range(0, 9)]);
        tap(SC_ENTER);
      end else if (pick < 80) begin
        sample_switches(SW_W'($urandom));
      end else if (pick < 90) begin
        press(8'($urandom));
      end else if (pick < 95) begin
        press(SC_BREAK);
      end else if (pick < 98) begin
        send(KIND_UNKNOWN, 8'($urandom), 2'($urandom), SW_W'($urandom));
      end else begin
        choose_group(GROUP_UNUSED);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d items and %0d results: %0d new displays, %0d stored values",
             items_sent, tracker.results_seen, tracker.displays_seen, tracker.commits);
    $display("input held back for %0d cycles; device count ended at %0d",
             held_back_cycles, tracker.device_count);
    if (tracker.mismatches == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
